[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/iec_pkg.sv]
// ----------------------------------------------------------------------------
// iec_pkg
// Types, codes and constants of the input event coalescer
// ----------------------------------------------------------------------------
package iec_pkg;

  // default number of tracked devices
  localparam int DEVICES_DEF = 8;

  // raw event types
  localparam logic [15:0] TYPE_SYNC = 16'h0000;
  localparam logic [15:0] TYPE_KEY  = 16'h0001;
  localparam logic [15:0] TYPE_REL  = 16'h0002;

  // relative axis codes
  localparam logic [15:0] AXIS_X     = 16'h0000;
  localparam logic [15:0] AXIS_Y     = 16'h0001;
  localparam logic [15:0] AXIS_WHEEL = 16'h0008;

  // sync kind
  localparam logic [15:0] SYNC_REPORT = 16'h0000;

  // left, right and middle button codes
  localparam logic [15:0] BTN_FIRST = 16'h0110;
  localparam logic [15:0] BTN_LAST  = 16'h0112;

  // timestamp scaling
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [9:0]  USEC_PER_MS  = 10'd1000;
  // floor(u / 1000) == (u * MS_RECIP) >> MS_SHIFT for every 20-bit u
  localparam logic [20:0] MS_RECIP     = 21'd1073742;
  localparam int          MS_SHIFT     = 30;
  localparam int          MS_Q_W       = 11;

  // field widths
  localparam int DEV_W   = 3;
  localparam int TYPE_W  = 16;
  localparam int CODE_W  = 16;
  localparam int VAL_W   = 32;
  localparam int SEC_W   = 32;
  localparam int USUB_W  = 20;
  localparam int USEC_W  = 52;
  localparam int MS_W    = 42;
  localparam int MASK_W  = 8;

  // stream payload widths
  localparam int IN_FIELDS_W  = DEV_W + CODE_W + VAL_W + SEC_W + USUB_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = DEV_W + CODE_W + 1 + 3 * VAL_W + USEC_W + MS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // result kinds
  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_MOTION = 2'd2,
    KIND_WHEEL  = 2'd3
  } kind_t;

  // one raw input event
  typedef struct packed {
    logic [DEV_W-1:0]         dev;
    logic [TYPE_W-1:0]        ev_type;
    logic [CODE_W-1:0]        code;
    logic signed [VAL_W-1:0]  value;
    logic [SEC_W-1:0]         sec;
    logic [USUB_W-1:0]        usec_part;
  } item_t;

  // one result event
  typedef struct packed {
    kind_t                    kind;
    logic [DEV_W-1:0]         dev;
    logic [CODE_W-1:0]        code;
    logic                     pressed;
    logic signed [VAL_W-1:0]  dx;
    logic signed [VAL_W-1:0]  dy;
    logic signed [VAL_W-1:0]  wheel;
    logic [USEC_W-1:0]        usec;
    logic [MS_W-1:0]          ms;
    logic                     last;
  } res_t;

  // results produced by one raw event
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } core_out_t;

  // signed add that clamps to the 32-bit range
  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

[design/input_event_coalescer.sv]
// ----------------------------------------------------------------------------
// input_event_coalescer
// Turns raw device events into key, button, motion and wheel events
//
//   channel  direction  payload                                   handshake
//   in_      slave      tdata: device, code, value, sec, usec     tvalid/tready
//                       tuser: event type
//   out_     master     tdata: device, code, pressed, dx, dy,     tvalid/tready
//                              wheel, stamp_usec, stamp_ms
//                       tuser: event kind, tlast: final result
//   cfg_     write      pointer-capable mask                      wr_en
//
// One raw event a cycle while the output is ready; each event passes through
// the input register and then the result slot registers. A sync report with
// both motion and wheel pending gives two results and holds the input
// register while the second one drains through the output register. Reset
// (rst_n low, synchronous) clears all accumulators, button bits, the mask and
// both registers' valid state. A stalled output keeps its result and the
// input register still takes one more event behind it.
// ----------------------------------------------------------------------------
module input_event_coalescer #(
  parameter int DEVICES = iec_pkg::DEVICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input events
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // device, event_code, event_value, time_sec, time_usec_part
  input  logic [iec_pkg::IN_TDATA_W-1:0]  in_tdata,
  // event_type
  input  logic [iec_pkg::TYPE_W-1:0]      in_tuser,
  // result events
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // source_device, key_or_button, pressed, delta_x, delta_y, wheel_amount,
  // stamp_usec, stamp_ms
  output logic [iec_pkg::OUT_TDATA_W-1:0] out_tdata,
  // event_kind
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [iec_pkg::MASK_W-1:0]      cfg_wr_data
);

  logic                  in_vld_r, in_vld_nxt;
  iec_pkg::item_t        item_r, item_in;
  iec_pkg::res_t         slot0_r, slot0_nxt;
  iec_pkg::res_t         slot1_r, slot1_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  out_fire;
  logic                  in_fire;
  logic [1:0]            remaining;
  logic                  take;
  iec_pkg::core_out_t    core_res;

  // unpack the input payload
  always_comb begin
    item_in           = '0;
    item_in.dev       = in_tdata[0 +: iec_pkg::DEV_W];
    item_in.code      = in_tdata[iec_pkg::DEV_W +: iec_pkg::CODE_W];
    item_in.value     = in_tdata[iec_pkg::DEV_W + iec_pkg::CODE_W +: iec_pkg::VAL_W];
    item_in.sec       = in_tdata[iec_pkg::DEV_W + iec_pkg::CODE_W + iec_pkg::VAL_W
                                 +: iec_pkg::SEC_W];
    item_in.usec_part = in_tdata[iec_pkg::DEV_W + iec_pkg::CODE_W + iec_pkg::VAL_W
                                 + iec_pkg::SEC_W +: iec_pkg::USUB_W];
    item_in.ev_type   = in_tuser;
  end

  // decode and device state
  iec_core #(
    .DEVICES (DEVICES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_i      (item_r),
    .take_i      (take),
    .core_o      (core_res)
  );

  // handshake and flow control
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_fire   = out_tvalid && out_tready;
  assign remaining  = cnt_r - 2'(out_fire);
  assign take       = in_vld_r && (remaining == 2'd0);
  assign in_tready  = !in_vld_r || take;
  assign in_fire    = in_tvalid && in_tready;

  // next input valid and result slots
  always_comb begin
    in_vld_nxt = in_fire ? 1'b1 : (take ? 1'b0 : in_vld_r);
    slot0_nxt  = slot0_r;
    slot1_nxt  = slot1_r;
    cnt_nxt    = cnt_r;
    if (take) begin
      slot0_nxt = core_res.first;
      slot1_nxt = core_res.second;
      cnt_nxt   = core_res.cnt;
    end else if (out_fire) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      in_vld_r <= in_vld_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_in;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  // pack the result payload
  assign out_tdata = {{iec_pkg::OUT_PAD_W{1'b0}}, slot0_r.ms, slot0_r.usec, slot0_r.wheel,
                      slot0_r.dy, slot0_r.dx, slot0_r.pressed, slot0_r.code, slot0_r.dev};
  assign out_tuser = slot0_r.kind;
  assign out_tlast = slot0_r.last;

endmodule

[design/iec_stamp.sv]
// ----------------------------------------------------------------------------
// iec_stamp
// Converts the seconds and microseconds timestamp to microseconds and
// milliseconds
// ----------------------------------------------------------------------------
module iec_stamp (
  input  logic [iec_pkg::SEC_W-1:0]  sec_i,
  input  logic [iec_pkg::USUB_W-1:0] usec_part_i,
  output logic [iec_pkg::USEC_W-1:0] stamp_usec_o,
  output logic [iec_pkg::MS_W-1:0]   stamp_ms_o
);

  localparam int PROD_W = iec_pkg::USUB_W + 21;

  logic [PROD_W-1:0]           ms_prod;
  logic [iec_pkg::MS_Q_W-1:0]  ms_part;

  // seconds scaled to microseconds plus the sub-second part
  assign stamp_usec_o = iec_pkg::USEC_W'(sec_i) * iec_pkg::USEC_W'(iec_pkg::USEC_PER_SEC)
                      + iec_pkg::USEC_W'(usec_part_i);

  // sub-second part over 1000 by reciprocal multiply
  assign ms_prod = PROD_W'(usec_part_i) * PROD_W'(iec_pkg::MS_RECIP);
  assign ms_part = ms_prod[iec_pkg::MS_SHIFT +: iec_pkg::MS_Q_W];

  // whole seconds are an exact multiple of a millisecond
  assign stamp_ms_o = iec_pkg::MS_W'(sec_i) * iec_pkg::MS_W'(iec_pkg::USEC_PER_MS)
                    + iec_pkg::MS_W'(ms_part);

endmodule

[design/iec_core.sv]
// ----------------------------------------------------------------------------
// iec_core
// Per-device accumulators and button state, and the decode that turns one
// raw event into up to two result events
// ----------------------------------------------------------------------------
module iec_core #(
  parameter int DEVICES = iec_pkg::DEVICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [iec_pkg::MASK_W-1:0] cfg_wr_data,
  input  iec_pkg::item_t             item_i,
  input  logic                       take_i,
  output iec_pkg::core_out_t         core_o
);

  localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  logic signed [iec_pkg::VAL_W-1:0] pend_x_r [DEVICES];
  logic signed [iec_pkg::VAL_W-1:0] pend_y_r [DEVICES];
  logic signed [iec_pkg::VAL_W-1:0] pend_w_r [DEVICES];
  logic [2:0]                       btn_r    [DEVICES];
  logic [iec_pkg::MASK_W-1:0]       mask_r;

  logic [IDX_W-1:0]                 dev_idx;
  logic                             in_range;
  logic signed [iec_pkg::VAL_W-1:0] cur_x, cur_y, cur_w;
  logic [2:0]                       cur_btn;
  logic signed [iec_pkg::VAL_W-1:0] px_nxt, py_nxt, pw_nxt;
  logic [2:0]                       btn_nxt;
  logic                             pressed;
  logic [1:0]                       btn_idx;
  logic [2:0]                       btn_bit;
  logic [2:0]                       btn_want;
  logic                             is_btn;
  logic signed [iec_pkg::VAL_W-1:0] acc_sel;
  logic signed [iec_pkg::VAL_W-1:0] acc_sum;
  logic                             has_motion;
  logic                             has_wheel;
  logic [1:0]                       cnt;
  logic [iec_pkg::USEC_W-1:0]       stamp_usec;
  logic [iec_pkg::MS_W-1:0]         stamp_ms;
  iec_pkg::res_t                    base, res_a, res_b;

  // timestamp conversion
  iec_stamp u_stamp (
    .sec_i        (item_i.sec),
    .usec_part_i  (item_i.usec_part),
    .stamp_usec_o (stamp_usec),
    .stamp_ms_o   (stamp_ms)
  );

  assign dev_idx  = IDX_W'(item_i.dev);
  assign in_range = 32'(item_i.dev) < 32'(DEVICES);

  // event decode and next device state
  always_comb begin
    cur_x   = pend_x_r[dev_idx];
    cur_y   = pend_y_r[dev_idx];
    cur_w   = pend_w_r[dev_idx];
    cur_btn = btn_r[dev_idx];
    px_nxt  = cur_x;
    py_nxt  = cur_y;
    pw_nxt  = cur_w;
    btn_nxt = cur_btn;

    base      = '0;
    base.dev  = item_i.dev;
    base.usec = stamp_usec;
    base.ms   = stamp_ms;
    res_a     = base;
    res_b     = base;
    cnt       = 2'd0;

    pressed  = (item_i.value != '0);
    btn_idx  = 2'(item_i.code - iec_pkg::BTN_FIRST);
    btn_bit  = 3'b001 << btn_idx;
    btn_want = pressed ? btn_bit : 3'b000;
    is_btn   = mask_r[item_i.dev] && (item_i.code >= iec_pkg::BTN_FIRST)
             && (item_i.code <= iec_pkg::BTN_LAST);

    // one shared saturating adder for the addressed axis
    acc_sel = (item_i.code == iec_pkg::AXIS_X) ? cur_x :
              (item_i.code == iec_pkg::AXIS_Y) ? cur_y : cur_w;
    acc_sum = iec_pkg::sat_add(acc_sel, item_i.value);

    has_motion = (cur_x != '0) || (cur_y != '0);
    has_wheel  = (cur_w != '0);

    if (in_range) begin
      case (item_i.ev_type)
        iec_pkg::TYPE_KEY: begin
          if (is_btn) begin
            // button reported only on a change of its stored bit
            if ((cur_btn & btn_bit) != btn_want) begin
              btn_nxt       = (cur_btn & ~btn_bit) | btn_want;
              res_a.kind    = iec_pkg::KIND_BUTTON;
              res_a.code    = item_i.code;
              res_a.pressed = pressed;
              cnt           = 2'd1;
            end
          end else begin
            res_a.kind    = iec_pkg::KIND_KEY;
            res_a.code    = item_i.code;
            res_a.pressed = pressed;
            cnt           = 2'd1;
          end
        end
        iec_pkg::TYPE_REL: begin
          case (item_i.code)
            iec_pkg::AXIS_X:     px_nxt = acc_sum;
            iec_pkg::AXIS_Y:     py_nxt = acc_sum;
            iec_pkg::AXIS_WHEEL: pw_nxt = acc_sum;
            default: ;
          endcase
        end
        iec_pkg::TYPE_SYNC: begin
          if (item_i.code == iec_pkg::SYNC_REPORT) begin
            // motion first, then the wheel
            if (has_motion) begin
              res_a.kind = iec_pkg::KIND_MOTION;
              res_a.dx   = cur_x;
              res_a.dy   = cur_y;
              px_nxt     = '0;
              py_nxt     = '0;
            end
            if (has_wheel) begin
              pw_nxt = '0;
              if (has_motion) begin
                res_b.kind  = iec_pkg::KIND_WHEEL;
                res_b.wheel = cur_w;
              end else begin
                res_a.kind  = iec_pkg::KIND_WHEEL;
                res_a.wheel = cur_w;
              end
            end
            cnt = 2'(has_motion) + 2'(has_wheel);
          end
        end
        default: ;
      endcase
    end

    // mark the final result of this event
    res_a.last = (cnt == 2'd1);
    res_b.last = (cnt == 2'd2);

    core_o.cnt    = cnt;
    core_o.first  = res_a;
    core_o.second = res_b;
  end

  // device state and pointer mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEVICES; i++) begin
        pend_x_r[i] <= '0;
        pend_y_r[i] <= '0;
        pend_w_r[i] <= '0;
        btn_r[i]    <= '0;
      end
      mask_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      if (take_i && in_range) begin
        pend_x_r[dev_idx] <= px_nxt;
        pend_y_r[dev_idx] <= py_nxt;
        pend_w_r[dev_idx] <= pw_nxt;
        btn_r[dev_idx]    <= btn_nxt;
      end
    end
  end

endmodule

[design/iec_checker.sv]
// ----------------------------------------------------------------------------
// iec_checker
// Port-level checks of the input event coalescer's result stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iec_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [iec_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]                      out_tuser,
  input  logic                            out_tlast
);

  localparam int CODE_LO  = iec_pkg::DEV_W;
  localparam int PRESS_B  = CODE_LO + iec_pkg::CODE_W;
  localparam int DX_LO    = PRESS_B + 1;
  localparam int DY_LO    = DX_LO + iec_pkg::VAL_W;
  localparam int WH_LO    = DY_LO + iec_pkg::VAL_W;

  logic is_key, is_motion, is_wheel;

  assign is_key    = (out_tuser == iec_pkg::KIND_KEY) || (out_tuser == iec_pkg::KIND_BUTTON);
  assign is_motion = (out_tuser == iec_pkg::KIND_MOTION);
  assign is_wheel  = (out_tuser == iec_pkg::KIND_WHEEL);

  // a stalled result holds
  `ASSERT_RUN(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // no result right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // key and button results are single and carry no motion
  `ASSERT_RUN(a_key_clean, clk, rst_n, out_tvalid && is_key |-> out_tlast && (out_tdata[WH_LO + iec_pkg::VAL_W - 1:DX_LO] == '0), "key result with motion or not last")

  // motion results carry nonzero motion and nothing else
  `ASSERT_RUN(a_motion_clean, clk, rst_n, out_tvalid && is_motion |-> (out_tdata[DY_LO + iec_pkg::VAL_W - 1:DX_LO] != '0) && (out_tdata[WH_LO + iec_pkg::VAL_W - 1:WH_LO] == '0) && (out_tdata[PRESS_B:CODE_LO] == '0), "malformed motion result")

  // a wheel result is always the final one and nonzero
  `ASSERT_RUN(a_wheel_last, clk, rst_n, out_tvalid && is_wheel |-> out_tlast && (out_tdata[WH_LO + iec_pkg::VAL_W - 1:WH_LO] != '0), "malformed wheel result")

endmodule

bind input_event_coalescer iec_checker u_iec_checker (.*);
